// ===== hdl/boundary_tag_pool_allocator_macros.svh =====
// Assertion macros used by the checker file.
`ifndef BOUNDARY_TAG_POOL_ALLOCATOR_MACROS_SVH
`define BOUNDARY_TAG_POOL_ALLOCATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BTPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btpa check failed");

// Consequent must hold in the cycle after the antecedent.
`define BTPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btpa check failed");

`endif

// ===== hdl/btpa_pkg.sv =====
package btpa_pkg;

    // Default pool size in bytes
    localparam int POOL_BYTES_DEF = 4096;

    // Stored tag width (saturated) and internal address/sum width
    localparam int TAG_W  = 21;
    localparam int SUM_W  = 24;
    localparam int SIZE_W = 12;
    localparam int OFS_W  = 12;

    localparam int TAG_MAX = 2 ** (TAG_W - 1) - 1;
    localparam int TAG_MIN = -(2 ** (TAG_W - 1));

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_ALLOC_OK   = 2'd0,
        ST_ALLOC_FAIL = 2'd1,
        ST_FREE_DONE  = 2'd2
    } t_status;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] req_size;
        logic [OFS_W-1:0]  free_offset;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [OFS_W-1:0] payload_offset;
    } t_rsp;

    typedef enum logic [4:0] {
        S_INIT0,
        S_INIT1,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SPLIT_CHK,
        S_SPLIT_W0,
        S_SPLIT_W1,
        S_SPLIT_W2,
        S_SPLIT_W3,
        S_MARK_W0,
        S_MARK_W1,
        S_FREE_RD0,
        S_FREE_RD1,
        S_FREE_RD2,
        S_FREE_CHK,
        S_FREE_W0,
        S_FREE_W1
    } t_state;

    // Clamp a wide signed value to the stored tag range
    function automatic logic signed [TAG_W-1:0] sat_tag(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = $signed(SUM_W'(TAG_MAX));
        lo = $signed(SUM_W'(TAG_MIN));
        if (v > hi) begin
            return $signed(TAG_W'(TAG_MAX));
        end else if (v < lo) begin
            return $signed(TAG_W'(TAG_MIN));
        end else begin
            return $signed(v[TAG_W-1:0]);
        end
    endfunction

endpackage

// ===== hdl/boundary_tag_pool_allocator.sv =====
// Channel   | Ports                      | Handshake
// ----------+----------------------------+------------------------------------
// request   | start, busy, i_req         | taken when start=1 and busy=0
// result    | o_done, o_rsp              | one-cycle strobe, no back-pressure
//
// Steps: allocate = read and check of each block the first-fit scan visits, a
// halving check, four writes per halving, two to mark; free = three reads, a
// merge check, two writes (first step only for offsets below 4). One single-port
// tag RAM and one shared address adder carry all tag traffic. The result strobe
// is registered from the last step. After reset the block writes both end tags
// (busy high). Results cannot be stalled: o_done is high for exactly one cycle.
module boundary_tag_pool_allocator #(
    parameter int POOL_BYTES = btpa_pkg::POOL_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  btpa_pkg::t_req  i_req,
    output logic            o_done,
    output btpa_pkg::t_rsp  o_rsp
);

    localparam int TAG_W = btpa_pkg::TAG_W;
    localparam int SUM_W = btpa_pkg::SUM_W;
    localparam int AW    = $clog2(POOL_BYTES);

    localparam logic signed [SUM_W-1:0] POOL_S   = SUM_W'(POOL_BYTES);
    localparam logic signed [TAG_W-1:0] POOL_TAG = TAG_W'(POOL_BYTES);
    localparam logic signed [SUM_W-1:0] K0       = SUM_W'(0);
    localparam logic signed [SUM_W-1:0] K4       = SUM_W'(4);
    localparam logic signed [SUM_W-1:0] K8       = SUM_W'(8);
    localparam logic signed [SUM_W-1:0] K16      = SUM_W'(16);

    btpa_pkg::t_state r_state, n_state;

    logic signed [SUM_W-1:0] r_h, n_h;
    logic signed [SUM_W-1:0] r_cur, n_cur;
    logic signed [SUM_W-1:0] r_base, n_base;
    logic signed [TAG_W-1:0] r_t, n_t;
    logic signed [TAG_W-1:0] r_pf, n_pf;
    logic [btpa_pkg::SIZE_W-1:0] r_size, n_size;
    logic                    r_done, n_done;
    btpa_pkg::t_rsp          r_rsp, n_rsp;

    // Tag RAM port
    logic signed [TAG_W-1:0] r_mem [POOL_BYTES];
    logic signed [TAG_W-1:0] r_rd_data;
    logic                    r_rd_oob;
    logic signed [SUM_W-1:0] op_a, op_b, addr;
    logic                    addr_ok;
    logic [AW-1:0]           idx;
    logic                    wr_en;
    logic signed [TAG_W-1:0] wr_data;

    // Datapath helpers
    logic signed [TAG_W-1:0] rd_val;
    logic signed [SUM_W-1:0] rd_ext, size_ext, t_ext, pf_ext;
    logic signed [SUM_W-1:0] h_sz, mag, nh, lim2, grant;
    logic signed [TAG_W-1:0] half, upper;
    logic                    next_free, prev_free;

    // Shared address adder and range check
    assign addr    = op_a + op_b;
    assign addr_ok = (addr >= K0) && (addr < POOL_S);
    assign idx     = addr[AW-1:0];

    // Out-of-pool reads return zero
    assign rd_val   = r_rd_oob ? '0 : r_rd_data;
    assign rd_ext   = SUM_W'(rd_val);
    assign size_ext = $signed(SUM_W'(r_size));
    assign t_ext    = SUM_W'(r_t);
    assign pf_ext   = SUM_W'(r_pf);
    assign h_sz     = r_h + size_ext;
    assign mag      = (rd_ext < K0) ? -rd_ext : rd_ext;
    assign nh       = r_h + mag;
    assign lim2     = (size_ext <<< 1) + K16;
    assign grant    = r_h + K4;
    assign half     = r_t >>> 1;
    assign upper    = r_t - half;
    assign next_free = rd_ext > K0;
    assign prev_free = (r_h != K0) && (pf_ext > K0);

    // Tag RAM: one access per cycle, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en && addr_ok) begin
            r_mem[idx] <= wr_data;
        end
        r_rd_data <= r_mem[idx];
        r_rd_oob  <= !addr_ok;
    end

    // Sequencer next state and working registers
    always_comb begin
        n_state = r_state;
        n_h     = r_h;
        n_cur   = r_cur;
        n_base  = r_base;
        n_t     = r_t;
        n_pf    = r_pf;
        n_size  = r_size;
        n_done  = 1'b0;
        n_rsp   = r_rsp;
        unique case (r_state)
            btpa_pkg::S_INIT0: n_state = btpa_pkg::S_INIT1;
            btpa_pkg::S_INIT1: n_state = btpa_pkg::S_IDLE;
            btpa_pkg::S_IDLE: begin
                if (start) begin
                    n_size = i_req.req_size;
                    if (i_req.req_type == btpa_pkg::REQ_ALLOC) begin
                        n_h     = K0;
                        n_state = btpa_pkg::S_SCAN_RD;
                    end else begin
                        n_h     = $signed(SUM_W'(i_req.free_offset)) - K4;
                        n_state = btpa_pkg::S_FREE_RD0;
                    end
                end
            end
            btpa_pkg::S_SCAN_RD: n_state = btpa_pkg::S_SCAN_CHK;
            btpa_pkg::S_SCAN_CHK: begin
                // pool end, zero tag or walking off the end all fail
                if (h_sz >= POOL_S) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: btpa_pkg::ST_ALLOC_FAIL, payload_offset: '0};
                    n_state = btpa_pkg::S_IDLE;
                end else if (rd_ext >= size_ext + K8) begin
                    n_t     = rd_val;
                    n_state = btpa_pkg::S_SPLIT_CHK;
                end else if (mag == K0 || nh >= POOL_S) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: btpa_pkg::ST_ALLOC_FAIL, payload_offset: '0};
                    n_state = btpa_pkg::S_IDLE;
                end else begin
                    n_h     = nh;
                    n_state = btpa_pkg::S_SCAN_RD;
                end
            end
            btpa_pkg::S_SPLIT_CHK: begin
                if (t_ext > lim2) begin
                    n_state = btpa_pkg::S_SPLIT_W0;
                end else begin
                    n_state = btpa_pkg::S_MARK_W0;
                end
            end
            btpa_pkg::S_SPLIT_W0: n_state = btpa_pkg::S_SPLIT_W1;
            btpa_pkg::S_SPLIT_W1: n_state = btpa_pkg::S_SPLIT_W2;
            btpa_pkg::S_SPLIT_W2: n_state = btpa_pkg::S_SPLIT_W3;
            btpa_pkg::S_SPLIT_W3: begin
                n_t     = half;
                n_state = btpa_pkg::S_SPLIT_CHK;
            end
            btpa_pkg::S_MARK_W0: n_state = btpa_pkg::S_MARK_W1;
            btpa_pkg::S_MARK_W1: begin
                n_done  = 1'b1;
                n_rsp   = '{status: btpa_pkg::ST_ALLOC_OK, payload_offset: grant[11:0]};
                n_state = btpa_pkg::S_IDLE;
            end
            btpa_pkg::S_FREE_RD0: begin
                // payload offset below 4 is ignored
                if (r_h < K0) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: btpa_pkg::ST_FREE_DONE, payload_offset: '0};
                    n_state = btpa_pkg::S_IDLE;
                end else begin
                    n_state = btpa_pkg::S_FREE_RD1;
                end
            end
            btpa_pkg::S_FREE_RD1: begin
                n_cur   = -rd_ext;
                n_state = btpa_pkg::S_FREE_RD2;
            end
            btpa_pkg::S_FREE_RD2: begin
                n_pf    = rd_val;
                n_state = btpa_pkg::S_FREE_CHK;
            end
            btpa_pkg::S_FREE_CHK: begin
                // merge with free neighbors
                priority if (next_free && prev_free) begin
                    n_cur  = r_cur + rd_ext + pf_ext;
                    n_base = r_h - pf_ext;
                end else if (next_free) begin
                    n_cur  = r_cur + rd_ext;
                    n_base = r_h;
                end else if (prev_free) begin
                    n_cur  = r_cur + pf_ext;
                    n_base = r_h - pf_ext;
                end else begin
                    n_base = r_h;
                end
                n_state = btpa_pkg::S_FREE_W0;
            end
            btpa_pkg::S_FREE_W0: n_state = btpa_pkg::S_FREE_W1;
            btpa_pkg::S_FREE_W1: begin
                n_done  = 1'b1;
                n_rsp   = '{status: btpa_pkg::ST_FREE_DONE, payload_offset: '0};
                n_state = btpa_pkg::S_IDLE;
            end
            default: n_state = btpa_pkg::S_IDLE;
        endcase
    end

    // Tag RAM address operands and write data per state
    always_comb begin
        op_a    = r_h;
        op_b    = K0;
        wr_en   = 1'b0;
        wr_data = half;
        unique case (r_state)
            btpa_pkg::S_INIT0: begin
                op_a    = K0;
                wr_en   = 1'b1;
                wr_data = POOL_TAG;
            end
            btpa_pkg::S_INIT1: begin
                op_a    = POOL_S;
                op_b    = -K4;
                wr_en   = 1'b1;
                wr_data = POOL_TAG;
            end
            btpa_pkg::S_SPLIT_W0: begin
                wr_en   = 1'b1;
                wr_data = half;
            end
            btpa_pkg::S_SPLIT_W1: begin
                op_b    = SUM_W'(half);
                wr_en   = 1'b1;
                wr_data = upper;
            end
            btpa_pkg::S_SPLIT_W2: begin
                op_b    = SUM_W'(half) - K4;
                wr_en   = 1'b1;
                wr_data = half;
            end
            btpa_pkg::S_SPLIT_W3: begin
                op_b    = t_ext - K4;
                wr_en   = 1'b1;
                wr_data = upper;
            end
            btpa_pkg::S_MARK_W0: begin
                wr_en   = 1'b1;
                wr_data = btpa_pkg::sat_tag(-t_ext);
            end
            btpa_pkg::S_MARK_W1: begin
                op_b    = t_ext - K4;
                wr_en   = 1'b1;
                wr_data = btpa_pkg::sat_tag(-t_ext);
            end
            btpa_pkg::S_FREE_RD1: op_b = -K4;
            btpa_pkg::S_FREE_RD2: op_b = r_cur;
            btpa_pkg::S_FREE_W0: begin
                op_a    = r_base;
                wr_en   = 1'b1;
                wr_data = btpa_pkg::sat_tag(r_cur);
            end
            btpa_pkg::S_FREE_W1: begin
                op_a    = r_base;
                op_b    = r_cur - K4;
                wr_en   = 1'b1;
                wr_data = btpa_pkg::sat_tag(r_cur);
            end
            default: begin
                op_a = r_h;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btpa_pkg::S_INIT0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_h    <= n_h;
        r_cur  <= n_cur;
        r_base <= n_base;
        r_t    <= n_t;
        r_pf   <= n_pf;
        r_size <= n_size;
        r_rsp  <= n_rsp;
    end

    assign busy   = (r_state != btpa_pkg::S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

// ===== hdl/btpa_checker.sv =====
`include "boundary_tag_pool_allocator_macros.svh"

// Port-level checks on the allocator
module btpa_port_checks (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_done,
    input btpa_pkg::t_rsp o_rsp
);

    // an accepted word leaves the block busy in the following cycle
    `BTPA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a result is shown only once the sequencer is back at rest
    `BTPA_ASSERT_NOW(a_done_idle, o_done, !busy)
    // each result is a single-cycle strobe
    `BTPA_ASSERT_NEXT(a_done_pulse, o_done, !o_done)
    // failed allocations and frees carry a zero offset
    `BTPA_ASSERT_NOW(a_zero_ofs, o_done && o_rsp.status != btpa_pkg::ST_ALLOC_OK, o_rsp.payload_offset == '0)

endmodule

bind boundary_tag_pool_allocator btpa_port_checks u_btpa_port_checks (.*);
